// File: rtl/core/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Types and constants shared by the Roman numeral encoder modules.
// ----------------------------------------------------------------------------
package rne_pkg;

   localparam int unsigned VALUE_W = 12;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned NUM_POS = 4;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

   // ASCII letters
   localparam logic [CHAR_W-1:0] CHAR_NONE = 7'd0;
   localparam logic [CHAR_W-1:0] CHAR_M    = 7'd77;
   localparam logic [CHAR_W-1:0] CHAR_D    = 7'd68;
   localparam logic [CHAR_W-1:0] CHAR_C    = 7'd67;
   localparam logic [CHAR_W-1:0] CHAR_L    = 7'd76;
   localparam logic [CHAR_W-1:0] CHAR_X    = 7'd88;
   localparam logic [CHAR_W-1:0] CHAR_V    = 7'd86;
   localparam logic [CHAR_W-1:0] CHAR_I    = 7'd73;

   // One classified request: error flag and decimal digits, index 0 = units
   typedef struct packed {
      logic                             err;
      logic [NUM_POS-1:0][DIGIT_W-1:0] digits;
   } rne_item_type;

endpackage

// File: rtl/core/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front
// Three-stage pipeline that range-checks a request and splits it into
// thousands, hundreds, tens and units digits by constant compares.
// ----------------------------------------------------------------------------
module rne_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rne_pkg::VALUE_W-1:0]       req_value,
   output logic                              item_valid,
   input  logic                              item_ready,
   output rne_pkg::rne_item_type             item
);

   // stage 1: range check and thousands
   logic        s1_valid_ff;
   logic        s1_err_ff,   s1_err_in;
   logic [3:0]  s1_th_ff,    s1_th_in;
   logic [9:0]  s1_rem_ff,   s1_rem_in;
   // stage 2: hundreds
   logic        s2_valid_ff;
   logic        s2_err_ff;
   logic [3:0]  s2_th_ff;
   logic [3:0]  s2_h_ff,     s2_h_in;
   logic [6:0]  s2_rem_ff,   s2_rem_in;
   // stage 3: tens and units
   logic        s3_valid_ff;
   rne_pkg::rne_item_type s3_item_ff, s3_item_in;
   logic [3:0]  tens;
   logic [6:0]  rem_units;

   logic s1_free, s2_free, s3_free;

   assign s3_free   = !s3_valid_ff || item_ready;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;

   always_comb begin
      logic [11:0] sub;
      s1_err_in = (req_value == '0) || (req_value > rne_pkg::VALUE_MAX);
      priority if (req_value >= 12'd3000) begin
         s1_th_in = 4'd3;
         sub      = 12'd3000;
      end else if (req_value >= 12'd2000) begin
         s1_th_in = 4'd2;
         sub      = 12'd2000;
      end else if (req_value >= 12'd1000) begin
         s1_th_in = 4'd1;
         sub      = 12'd1000;
      end else begin
         s1_th_in = 4'd0;
         sub      = 12'd0;
      end
      // out of range values wrap here; the error flag covers them
      s1_rem_in = 10'(req_value - sub);
   end

   always_comb begin
      logic [9:0] r;
      s2_h_in = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (s1_rem_ff >= 10'(k * 100)) begin
            s2_h_in = s2_h_in + 4'd1;
         end
      end
      r         = s1_rem_ff - ({6'd0, s2_h_in} * 10'd100);
      s2_rem_in = r[6:0];
   end

   always_comb begin
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (s2_rem_ff >= 7'(k * 10)) begin
            tens = tens + 4'd1;
         end
      end
      rem_units            = s2_rem_ff - ({3'd0, tens} * 7'd10);
      s3_item_in.err       = s2_err_ff;
      s3_item_in.digits[3] = s2_th_ff;
      s3_item_in.digits[2] = s2_h_ff;
      s3_item_in.digits[1] = tens;
      s3_item_in.digits[0] = rem_units[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_err_ff <= s1_err_in;
         s1_th_ff  <= s1_th_in;
         s1_rem_ff <= s1_rem_in;
      end
      if (s2_free) begin
         s2_err_ff <= s1_err_ff;
         s2_th_ff  <= s1_th_ff;
         s2_h_ff   <= s2_h_in;
         s2_rem_ff <= s2_rem_in;
      end
      if (s3_free) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign item_valid = s3_valid_ff;
   assign item       = s3_item_ff;

endmodule

// File: rtl/core/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue
// Small FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module rne_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rne_pkg::rne_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output rne_pkg::rne_item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rne_pkg::rne_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back
// Sequencer that walks the digits of one request and emits one numeral
// letter per cycle into a registered response slot while rsp_ready does not stall it.
// ----------------------------------------------------------------------------
module rne_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  rne_pkg::rne_item_type         item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rne_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                          rsp_error,
   output logic                          rsp_last
);

   typedef enum logic [1:0] {
      SYM_ONE,
      SYM_FIVE,
      SYM_TEN
   } sym_type;

   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] n;
      unique case (d)
         4'd1:    n = 3'd1;
         4'd2:    n = 3'd2;
         4'd3:    n = 3'd3;
         4'd4:    n = 3'd2;
         4'd5:    n = 3'd1;
         4'd6:    n = 3'd2;
         4'd7:    n = 3'd3;
         4'd8:    n = 3'd4;
         4'd9:    n = 3'd2;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic sym_type digit_sym(input logic [3:0] d, input logic [1:0] k);
      sym_type s;
      if (d == 4'd4) begin
         s = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
      end else if (d == 4'd9) begin
         s = (k == 2'd0) ? SYM_ONE : SYM_TEN;
      end else if (d >= 4'd5) begin
         s = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
      end else begin
         s = SYM_ONE;
      end
      return s;
   endfunction

   function automatic logic [rne_pkg::CHAR_W-1:0] letter(input logic [1:0] pos,
                                                          input sym_type s);
      logic [rne_pkg::CHAR_W-1:0] c;
      unique case (pos)
         2'd3: c = rne_pkg::CHAR_M;
         2'd2: c = (s == SYM_ONE) ? rne_pkg::CHAR_C :
                   (s == SYM_FIVE) ? rne_pkg::CHAR_D : rne_pkg::CHAR_M;
         2'd1: c = (s == SYM_ONE) ? rne_pkg::CHAR_X :
                   (s == SYM_FIVE) ? rne_pkg::CHAR_L : rne_pkg::CHAR_C;
         default: c = (s == SYM_ONE) ? rne_pkg::CHAR_I :
                      (s == SYM_FIVE) ? rne_pkg::CHAR_V : rne_pkg::CHAR_X;
      endcase
      return c;
   endfunction

   logic                  busy_ff;
   rne_pkg::rne_item_type cur_ff;
   logic [1:0]            pos_ff, pos_in;
   logic [1:0]            k_ff;
   logic                  rsp_valid_ff;
   logic [rne_pkg::CHAR_W-1:0] rsp_char_ff, char_in;
   logic                  rsp_error_ff;
   logic                  rsp_last_ff;

   logic [3:0] cur_dig;
   logic       out_free, fire, digit_done, lower_nz, is_last, load;
   logic [1:0] next_pos, load_pos;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fire       = busy_ff && out_free;
   assign cur_dig    = cur_ff.digits[pos_ff];
   assign digit_done = ({1'b0, k_ff} + 3'd1) == digit_len(cur_dig);
   assign is_last    = cur_ff.err || (digit_done && !lower_nz);
   assign load       = item_valid && (!busy_ff || (fire && is_last));
   assign item_ready = !busy_ff || (fire && is_last);
   assign char_in    = cur_ff.err ? rne_pkg::CHAR_NONE
                                  : letter(pos_ff, digit_sym(cur_dig, k_ff));

   // highest nonzero digit below the current one
   always_comb begin
      lower_nz = 1'b0;
      next_pos = 2'd0;
      for (int i = 0; i < rne_pkg::NUM_POS; i++) begin
         if ((2'(i) < pos_ff) && (cur_ff.digits[i] != '0)) begin
            lower_nz = 1'b1;
            next_pos = 2'(i);
         end
      end
   end

   // highest nonzero digit of an incoming request
   always_comb begin
      load_pos = 2'd0;
      for (int i = 0; i < rne_pkg::NUM_POS; i++) begin
         if (item.digits[i] != '0) begin
            load_pos = 2'(i);
         end
      end
   end

   assign pos_in = load ? load_pos : next_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (fire && is_last) begin
            busy_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= item;
         pos_ff <= pos_in;
         k_ff   <= 2'd0;
      end else if (fire) begin
         if (digit_done) begin
            pos_ff <= pos_in;
            k_ff   <= 2'd0;
         end else begin
            k_ff <= k_ff + 2'd1;
         end
      end
      if (fire) begin
         rsp_char_ff  <= char_in;
         rsp_error_ff <= cur_ff.err;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_error     = rsp_error_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: rtl/core/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit integer to its Roman numeral, one ASCII letter per response.
// ----------------------------------------------------------------------------
// Each request produces one response per numeral letter, 1 to 15 responses
// (3888 is the longest), the final one flagged by rsp_last; zero or a value
// above 3999 produces a single response with rsp_error set and code 0. The
// letter sequencer emits one letter per cycle while the output is not held
// by rsp_ready, and numerals follow one another with no gap when the next
// request already waits in the queue. A request passes the three digit
// split stages and then the queue before the sequencer takes it up, and
// its first letter is registered into the response slot after that; up to
// QUEUE_DEPTH split requests wait in the queue while a long numeral drains.
module roman_numeral_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rne_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rne_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic                           rsp_error,
   output logic                           rsp_last
);

   logic                  front_valid, front_ready;
   rne_pkg::rne_item_type front_item;
   logic                  queue_valid, queue_ready;
   rne_pkg::rne_item_type queue_item;

   rne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   rne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   rne_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (queue_valid),
      .item_ready    (queue_ready),
      .item          (queue_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_error     (rsp_error),
      .rsp_last      (rsp_last)
   );

   a_error_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && rsp_char_code == rne_pkg::CHAR_NONE))
      else $error("error response must be a single empty letter");

   a_letter_legal : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_error) |->
         (rsp_char_code == rne_pkg::CHAR_M || rsp_char_code == rne_pkg::CHAR_D ||
          rsp_char_code == rne_pkg::CHAR_C || rsp_char_code == rne_pkg::CHAR_L ||
          rsp_char_code == rne_pkg::CHAR_X || rsp_char_code == rne_pkg::CHAR_V ||
          rsp_char_code == rne_pkg::CHAR_I))
      else $error("response letter is not a numeral letter");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_error_after_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) ##1 rsp_valid |-> !rsp_error)
      else $error("error response inside a numeral");

endmodule
